### rtl/core/dbft_pkg.sv
package dbft_pkg;

  // Field widths of the stream payloads.
  localparam int unsigned BlockW   = 32;
  localparam int unsigned SlotW    = 5;
  localparam int unsigned CountW   = 6;
  localparam int unsigned BarrierW = 64;
  localparam int unsigned KindW    = 2;
  localparam int unsigned StatusW  = 2;
  localparam int unsigned OutDataW = 112;
  localparam int unsigned OutPadW  = OutDataW - StatusW - SlotW - BlockW - CountW - BarrierW;

  // Command carried in the input tuser.
  localparam logic CmdMark  = 1'b0;
  localparam logic CmdFlush = 1'b1;

  // Result kinds carried in the output tuser.
  localparam logic [KindW-1:0] KindMark  = 2'd0;
  localparam logic [KindW-1:0] KindWrite = 2'd1;
  localparam logic [KindW-1:0] KindDone  = 2'd2;

  // Result status codes.
  localparam logic [StatusW-1:0] StatusOk        = 2'd0;
  localparam logic [StatusW-1:0] StatusFull      = 2'd1;
  localparam logic [StatusW-1:0] StatusNoBackend = 2'd2;

  typedef enum logic [3:0] {
    StIdle  = 4'b0001,
    StMark  = 4'b0010,
    StFlush = 4'b0100,
    StDone  = 4'b1000
  } state_e;

  // Controls broadcast from the sequencer to every cell of the row.
  typedef struct packed {
    logic lookup;  // register the tag compare against the key
    logic write;   // the claiming cell stores the key and becomes valid
    logic shift;   // the flush token moves one cell along the row
    logic clear;   // the cell holding the token drops its entry
  } cell_ctrl_t;

endpackage

### rtl/core/dbft_cell.sv
module dbft_cell (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  dbft_pkg::cell_ctrl_t        ctrl_i,
  input  logic [dbft_pkg::BlockW-1:0] key_i,
  input  logic                        free_before_i,
  input  logic                        token_i,
  output logic                        free_before_o,
  output logic                        claim_o,
  output logic                        hit_o,
  output logic                        token_o,
  output logic                        valid_o,
  output logic [dbft_pkg::BlockW-1:0] block_o
);

  logic                        valid_q;
  logic                        hit_q;
  logic                        token_q;
  logic [dbft_pkg::BlockW-1:0] block_q;

  // This cell is the lowest free one when it is empty and no cell below is.
  assign claim_o       = ~valid_q & ~free_before_i;
  assign free_before_o = free_before_i | ~valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      hit_q   <= 1'b0;
      token_q <= 1'b0;
    end else begin
      if (ctrl_i.write && claim_o) begin
        valid_q <= 1'b1;
      end else if (ctrl_i.clear && token_q) begin
        valid_q <= 1'b0;
      end
      if (ctrl_i.lookup) begin
        hit_q <= valid_q & (block_q == key_i);
      end
      if (ctrl_i.shift) begin
        token_q <= token_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.write && claim_o) begin
      block_q <= key_i;
    end
  end

  assign hit_o   = hit_q;
  assign token_o = token_q;
  assign valid_o = valid_q;
  assign block_o = block_q;

endmodule

### rtl/core/dirty_block_flush_table.sv
// Mark: the tag compare is registered on the input transfer; the answer is loaded into
// the output register from the mark state once it is free; only then is a new item taken.
// Flush: the token walks the row of cells one slot per cycle while the output register has
// room for any valid entry; a flush without a backend goes straight to the done result.
// Reset clears the valid bits, the flush token, the barrier count and the backend flag;
// the stored block numbers are not reset and are only read through valid slots.
module dirty_block_flush_table #(
  parameter int unsigned SLOTS = 32
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // Configuration write: backend_present.
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic                             cfg_data_i,
  // Input stream.
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  input  logic [dbft_pkg::BlockW-1:0]      s_axis_tdata,   // block_number
  input  logic                             s_axis_tuser,   // command
  // Result stream.
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // status[1:0], slot[6:2], out_block[38:7], written_count[44:39],
  // barrier_count[108:45], zero pad[111:109]
  output logic [dbft_pkg::OutDataW-1:0]    m_axis_tdata,
  output logic [dbft_pkg::KindW-1:0]       m_axis_tuser,   // kind
  output logic                             m_axis_tlast    // last
);

  localparam int unsigned IdxW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int unsigned CntW = $clog2(SLOTS + 1);

  // Sequencer state.
  dbft_pkg::state_e state_q, state_d;
  logic                        backend_q;
  logic [dbft_pkg::BlockW-1:0] blk_q;
  logic                        fail_q;
  logic [IdxW-1:0]             scan_q;
  logic [CntW-1:0]             count_q;
  logic [dbft_pkg::BarrierW-1:0] barrier_q, barrier_d;

  // Output register.
  logic                            out_valid_q;
  logic [dbft_pkg::KindW-1:0]      out_kind_q,   out_kind_d;
  logic [dbft_pkg::StatusW-1:0]    out_status_q, out_status_d;
  logic [dbft_pkg::SlotW-1:0]      out_slot_q,   out_slot_d;
  logic [dbft_pkg::BlockW-1:0]     out_block_q,  out_block_d;
  logic [dbft_pkg::CountW-1:0]     out_count_q,  out_count_d;
  logic [dbft_pkg::BarrierW-1:0]   out_barrier_q, out_barrier_d;
  logic                            out_last_q,   out_last_d;
  logic                            out_free;
  logic                            load;

  // Row of cells.
  dbft_pkg::cell_ctrl_t        ctrl;
  logic [dbft_pkg::BlockW-1:0] key;
  logic [SLOTS:0]              free_chain;
  logic [SLOTS-1:0]            claim_vec;
  logic [SLOTS-1:0]            hit_vec;
  logic [SLOTS-1:0]            token_vec;
  logic [SLOTS-1:0]            token_in;
  logic [SLOTS-1:0]            valid_vec;
  logic [dbft_pkg::BlockW-1:0] block_vec [SLOTS];

  logic                        in_xfer;
  logic                        flush_start;
  logic                        hit_any;
  logic                        free_any;
  logic [IdxW-1:0]             hit_idx;
  logic [IdxW-1:0]             claim_idx;
  logic                        cur_valid;
  logic [dbft_pkg::BlockW-1:0] cur_block;
  logic                        advance;
  logic [IdxW+dbft_pkg::SlotW-1:0]  hit_idx_ext, claim_idx_ext, scan_ext;
  logic [CntW+dbft_pkg::CountW-1:0] count_ext;

  // Config register always writable; user must write only while idle (not enforced).
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      backend_q <= 1'b0;
    end else if (cfg_valid_i) begin
      backend_q <= cfg_data_i;
    end
  end

  // One item at a time: a new transfer is taken only when the sequencer is idle, but a
  // finished result may still sit in the output register.
  assign s_axis_tready = (state_q == dbft_pkg::StIdle);
  assign in_xfer       = s_axis_tvalid & s_axis_tready;
  assign flush_start   = in_xfer & (s_axis_tuser == dbft_pkg::CmdFlush) & backend_q;

  // The tag compare is registered in every cell straight off the input bus; the mark
  // itself stores the latched block number.
  assign key = (state_q == dbft_pkg::StIdle) ? s_axis_tdata : blk_q;

  assign out_free = ~out_valid_q | m_axis_tready;

  // Flush scan: the cell holding the token either has a valid entry that waits for room
  // in the output register, or it is empty and the token moves on at once.
  always_comb begin
    cur_valid = 1'b0;
    cur_block = '0;
    for (int i = 0; i < int'(SLOTS); i++) begin
      cur_valid = cur_valid | (token_vec[i] & valid_vec[i]);
      cur_block = cur_block | (token_vec[i] ? block_vec[i] : '0);
    end
  end

  assign advance = (state_q == dbft_pkg::StFlush) & (~cur_valid | out_free);

  // Match and claim vectors are one-hot at most, so an OR of indexes encodes them.
  always_comb begin
    hit_idx   = '0;
    claim_idx = '0;
    for (int i = 0; i < int'(SLOTS); i++) begin
      hit_idx   = hit_idx   | (hit_vec[i]   ? IdxW'(i) : '0);
      claim_idx = claim_idx | (claim_vec[i] ? IdxW'(i) : '0);
    end
  end

  assign hit_any  = |hit_vec;
  assign free_any = free_chain[SLOTS];

  always_comb begin
    ctrl.lookup = in_xfer;
    ctrl.write  = (state_q == dbft_pkg::StMark) & out_free & ~hit_any;
    ctrl.shift  = flush_start | advance;
    ctrl.clear  = advance;
  end

  assign free_chain[0] = 1'b0;
  assign token_in      = {token_vec[SLOTS-2:0], flush_start};

  for (genvar g = 0; g < SLOTS; g++) begin : g_cell
    dbft_cell u_cell (
      .clk_i         (clk_i),
      .rst_ni        (rst_ni),
      .ctrl_i        (ctrl),
      .key_i         (key),
      .free_before_i (free_chain[g]),
      .token_i       (token_in[g]),
      .free_before_o (free_chain[g+1]),
      .claim_o       (claim_vec[g]),
      .hit_o         (hit_vec[g]),
      .token_o       (token_vec[g]),
      .valid_o       (valid_vec[g]),
      .block_o       (block_vec[g])
    );
  end

  // Slot indexes and counts are cut or zero-extended to the result field widths.
  assign hit_idx_ext   = {{dbft_pkg::SlotW{1'b0}}, hit_idx};
  assign claim_idx_ext = {{dbft_pkg::SlotW{1'b0}}, claim_idx};
  assign scan_ext      = {{dbft_pkg::SlotW{1'b0}}, scan_q};
  assign count_ext     = {{dbft_pkg::CountW{1'b0}}, count_q};

  // The barrier count moves only when the flush wrote something.
  assign barrier_d = barrier_q + {{(dbft_pkg::BarrierW-1){1'b0}}, (count_q != '0)};

  // Sequencer and result selection.
  always_comb begin
    state_d       = state_q;
    load          = 1'b0;
    out_kind_d    = dbft_pkg::KindMark;
    out_status_d  = dbft_pkg::StatusOk;
    out_slot_d    = '0;
    out_block_d   = '0;
    out_count_d   = '0;
    out_barrier_d = '0;
    out_last_d    = 1'b1;
    unique case (state_q)
      dbft_pkg::StIdle: begin
        if (in_xfer) begin
          if (s_axis_tuser == dbft_pkg::CmdMark) begin
            state_d = dbft_pkg::StMark;
          end else if (backend_q) begin
            state_d = dbft_pkg::StFlush;
          end else begin
            state_d = dbft_pkg::StDone;
          end
        end
      end
      dbft_pkg::StMark: begin
        // A hit reuses its slot, a miss claims the lowest free one; a full table
        // answers with slot zero and leaves the row untouched.
        if (out_free) begin
          load    = 1'b1;
          state_d = dbft_pkg::StIdle;
          if (hit_any) begin
            out_slot_d = hit_idx_ext[dbft_pkg::SlotW-1:0];
          end else if (free_any) begin
            out_slot_d = claim_idx_ext[dbft_pkg::SlotW-1:0];
          end else begin
            out_status_d = dbft_pkg::StatusFull;
          end
        end
      end
      dbft_pkg::StFlush: begin
        if (cur_valid && out_free) begin
          load        = 1'b1;
          out_kind_d  = dbft_pkg::KindWrite;
          out_slot_d  = scan_ext[dbft_pkg::SlotW-1:0];
          out_block_d = cur_block;
          out_last_d  = 1'b0;
        end
        if (advance && token_vec[SLOTS-1]) begin
          state_d = dbft_pkg::StDone;
        end
      end
      dbft_pkg::StDone: begin
        if (out_free) begin
          load          = 1'b1;
          state_d       = dbft_pkg::StIdle;
          out_kind_d    = dbft_pkg::KindDone;
          out_status_d  = fail_q ? dbft_pkg::StatusNoBackend : dbft_pkg::StatusOk;
          out_count_d   = count_ext[dbft_pkg::CountW-1:0];
          out_barrier_d = barrier_d;
        end
      end
      default: begin
        state_d = dbft_pkg::StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= dbft_pkg::StIdle;
      fail_q      <= 1'b0;
      scan_q      <= '0;
      count_q     <= '0;
      barrier_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (in_xfer) begin
        fail_q  <= ~backend_q;
        scan_q  <= '0;
        count_q <= '0;
      end else if (advance) begin
        scan_q  <= scan_q + IdxW'(1);
        count_q <= count_q + CntW'(cur_valid);
      end
      if ((state_q == dbft_pkg::StDone) && out_free) begin
        barrier_q <= barrier_d;
      end
      if (load) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      blk_q <= s_axis_tdata;
    end
    if (load) begin
      out_kind_q    <= out_kind_d;
      out_status_q  <= out_status_d;
      out_slot_q    <= out_slot_d;
      out_block_q   <= out_block_d;
      out_count_q   <= out_count_d;
      out_barrier_q <= out_barrier_d;
      out_last_q    <= out_last_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_kind_q;
  assign m_axis_tlast  = out_last_q;
  assign m_axis_tdata  = {{dbft_pkg::OutPadW{1'b0}}, out_barrier_q, out_count_q,
                          out_block_q, out_slot_q, out_status_q};

  // A block number lives in at most one valid slot.
  a_single_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == dbft_pkg::StMark) |-> $onehot0(hit_vec))
    else $error("more than one slot matched the block number");

  // Exactly one cell holds the flush token while the scan runs.
  a_token_flush: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == dbft_pkg::StFlush) |-> $onehot(token_vec))
    else $error("flush token lost or duplicated");

  // Outside a scan no token is left in the row.
  a_token_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != dbft_pkg::StFlush) |-> (token_vec == '0))
    else $error("flush token left in the row");

  // A flush never writes out more slots than the table has.
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(SLOTS))
    else $error("write-out count beyond table size");

  // A refused flush reports nothing written.
  a_fail_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == dbft_pkg::StDone) && fail_q) |-> (count_q == '0))
    else $error("refused flush carries a write-out count");

endmodule
